/* sv/lpfd_pkg.sv */
// lpfd_pkg: field codes, field sizes and the result record of the frame deframer
// no dependencies; compiled first
`timescale 1ns / 1ps

package lpfd_pkg;

    // field codes, also the parser phase
    localparam logic [3:0] FC_BEGIN  = 4'd0;
    localparam logic [3:0] FC_TYPE   = 4'd1;
    localparam logic [3:0] FC_IDENT  = 4'd2;
    localparam logic [3:0] FC_REQID  = 4'd3;
    localparam logic [3:0] FC_TIME   = 4'd4;
    localparam logic [3:0] FC_LENGTH = 4'd5;
    localparam logic [3:0] FC_PREFIX = 4'd6;
    localparam logic [3:0] FC_BODY   = 4'd7;
    localparam logic [3:0] FC_END    = 4'd8;

    // byte count width in bits, then fixed field sizes in bytes
    localparam int COUNT_W      = 33;
    localparam int BEGIN_BYTES  = 2;
    localparam int TYPE_BYTES   = 1;
    localparam int IDENT_BYTES  = 8;
    localparam int TIME_BYTES   = 8;
    localparam int LENGTH_BYTES = 4;
    localparam int PREFIX_BYTES = 4;
    localparam int END_BYTES    = 2;

    // entries in the queue between parser and output stage
    localparam int QUEUE_DEPTH  = 2;

    typedef struct packed {
        logic [3:0]  field_code;
        logic [7:0]  byte_out;
        logic        frame_done;
        logic [7:0]  frame_type;
        logic [63:0] frame_ident;
        logic [63:0] frame_time;
        logic [31:0] body_length;
        logic [15:0] begin_mark;
        logic [15:0] end_mark;
    } rec_t;

endpackage

/* sv/lpfd_if.sv */
// lpfd_byte_if and lpfd_rec_if: valid/ready channels for input bytes and result records
// depends on nothing; follows lpfd_pkg in compile order
`timescale 1ns / 1ps

interface lpfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface lpfd_rec_if;
    logic        valid;
    logic        ready;
    logic [3:0]  field_code;
    logic [7:0]  byte_out;
    logic        frame_done;
    logic [7:0]  frame_type;
    logic [63:0] frame_ident;
    logic [63:0] frame_time;
    logic [31:0] body_length;
    logic [15:0] begin_mark;
    logic [15:0] end_mark;

    modport source (output valid, output field_code, output byte_out, output frame_done,
                    output frame_type, output frame_ident, output frame_time,
                    output body_length, output begin_mark, output end_mark,
                    input ready);
    modport sink   (input valid, input field_code, input byte_out, input frame_done,
                    input frame_type, input frame_ident, input frame_time,
                    input body_length, input begin_mark, input end_mark,
                    output ready);
endinterface

/* sv/lpfd_front.sv */
// lpfd_front: accepts stream bytes, tracks the field phase and assembles header values
// depends on lpfd_pkg and lpfd_byte_if
`timescale 1ns / 1ps

module lpfd_front #(
    parameter int REQUEST_ID_BYTES = 68
) (
    input  logic          clk,
    input  logic          rst_n,
    lpfd_byte_if.sink     rx,
    input  logic          full,
    output logic          push,
    output lpfd_pkg::rec_t rec
);
    import lpfd_pkg::*;

    logic [3:0]         phase_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [7:0]         type_reg;
    logic [63:0]        ident_reg;
    logic [63:0]        time_reg;
    logic [31:0]        length_reg;
    logic [15:0]        begin_reg;
    logic [15:0]        end_reg;

    logic [3:0]         ph;
    logic [3:0]         phase_adv;
    logic [COUNT_W-1:0] size;
    logic [COUNT_W-1:0] count_inc;
    logic               last;
    logic               done;
    logic [7:0]         type_next;
    logic [63:0]        ident_next;
    logic [63:0]        time_next;
    logic [31:0]        length_next;
    logic [15:0]        begin_next;
    logic [15:0]        end_next;

    // a transaction is taken whenever the queue has room
    assign rx.ready = !full;
    assign push     = rx.valid && !full;

    // classify the byte by phase and shift header bytes into their field
    always_comb
    begin
        ph          = (phase_reg > FC_END) ? FC_BEGIN : phase_reg;
        type_next   = type_reg;
        ident_next  = ident_reg;
        time_next   = time_reg;
        length_next = length_reg;
        begin_next  = begin_reg;
        end_next    = end_reg;
        size        = COUNT_W'(BEGIN_BYTES);
        phase_adv   = FC_TYPE;
        unique case (ph)
            FC_BEGIN:
            begin
                begin_next = {begin_reg[7:0], rx.byte_in};
                size       = COUNT_W'(BEGIN_BYTES);
                phase_adv  = FC_TYPE;
            end
            FC_TYPE:
            begin
                type_next = rx.byte_in;
                size      = COUNT_W'(TYPE_BYTES);
                phase_adv = FC_IDENT;
            end
            FC_IDENT:
            begin
                ident_next = {ident_reg[55:0], rx.byte_in};
                size       = COUNT_W'(IDENT_BYTES);
                phase_adv  = FC_REQID;
            end
            FC_REQID:
            begin
                size      = COUNT_W'(REQUEST_ID_BYTES);
                phase_adv = FC_TIME;
            end
            FC_TIME:
            begin
                time_next = {time_reg[55:0], rx.byte_in};
                size      = COUNT_W'(TIME_BYTES);
                phase_adv = FC_LENGTH;
            end
            FC_LENGTH:
            begin
                length_next = {length_reg[23:0], rx.byte_in};
                size        = COUNT_W'(LENGTH_BYTES);
                phase_adv   = FC_PREFIX;
            end
            FC_PREFIX:
            begin
                size      = COUNT_W'(PREFIX_BYTES);
                phase_adv = (length_reg == 32'd0) ? FC_END : FC_BODY;
            end
            FC_BODY:
            begin
                size      = {1'b0, length_reg};
                phase_adv = FC_END;
            end
            default:
            begin
                // end mark
                end_next  = {end_reg[7:0], rx.byte_in};
                size      = COUNT_W'(END_BYTES);
                phase_adv = FC_BEGIN;
            end
        endcase
        count_inc = count_reg + COUNT_W'(1);
        last      = (count_inc >= size);
        done      = last && (ph == FC_END);
    end

    // result record as seen after this byte
    always_comb
    begin
        rec.field_code  = ph;
        rec.byte_out    = rx.byte_in;
        rec.frame_done  = done;
        rec.frame_type  = type_next;
        rec.frame_ident = ident_next;
        rec.frame_time  = time_next;
        rec.body_length = length_next;
        rec.begin_mark  = begin_next;
        rec.end_mark    = done ? end_next : 16'd0;
    end

    // phase, byte count and header registers; cleared at end of frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= FC_BEGIN;
            count_reg  <= '0;
            type_reg   <= '0;
            ident_reg  <= '0;
            time_reg   <= '0;
            length_reg <= '0;
            begin_reg  <= '0;
            end_reg    <= '0;
        end
        else if (push)
        begin
            phase_reg <= last ? phase_adv : ph;
            count_reg <= last ? '0 : count_inc;
            if (done)
            begin
                type_reg   <= '0;
                ident_reg  <= '0;
                time_reg   <= '0;
                length_reg <= '0;
                begin_reg  <= '0;
                end_reg    <= '0;
            end
            else
            begin
                type_reg   <= type_next;
                ident_reg  <= ident_next;
                time_reg   <= time_next;
                length_reg <= length_next;
                begin_reg  <= begin_next;
                end_reg    <= end_next;
            end
        end
    end

`ifndef ASSERT_OFF
    // frame end only comes from the end-mark field
    a_done_in_end: assert property (@(posedge clk) disable iff (!rst_n)
        push && rec.frame_done |-> rec.field_code == FC_END)
        else $error("frame_done outside end mark");

    // after a frame ends the parser waits for a begin mark with clear headers
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        push && rec.frame_done |=> phase_reg == FC_BEGIN && count_reg == '0
            && length_reg == 32'd0)
        else $error("parser not restarted after frame end");

    // a body byte needs a nonzero declared length
    a_body_len: assert property (@(posedge clk) disable iff (!rst_n)
        push && rec.field_code == FC_BODY |-> length_reg != 32'd0)
        else $error("body byte with zero length");
`endif

endmodule

/* sv/lpfd_queue.sv */
// lpfd_queue: short queue of result records between parser and output stage
// depends on lpfd_pkg
`timescale 1ns / 1ps

module lpfd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lpfd_pkg::rec_t wr_data,
    input  logic           pop,
    output lpfd_pkg::rec_t rd_data,
    output logic           full,
    output logic           empty
);
    import lpfd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    rec_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    // storage write
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* sv/lpfd_back.sv */
// lpfd_back: output register that presents result records on the output channel
// depends on lpfd_pkg and lpfd_rec_if
`timescale 1ns / 1ps

module lpfd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           empty,
    input  lpfd_pkg::rec_t rd_data,
    output logic           pop,
    lpfd_rec_if.source     tx
);
    import lpfd_pkg::*;

    logic valid_reg;
    rec_t data_reg;

    // refill when the register is empty or its transaction completes
    assign pop = !empty && (!valid_reg || tx.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (tx.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= rd_data;
        end
    end

    // drive the channel
    assign tx.valid       = valid_reg;
    assign tx.field_code  = data_reg.field_code;
    assign tx.byte_out    = data_reg.byte_out;
    assign tx.frame_done  = data_reg.frame_done;
    assign tx.frame_type  = data_reg.frame_type;
    assign tx.frame_ident = data_reg.frame_ident;
    assign tx.frame_time  = data_reg.frame_time;
    assign tx.body_length = data_reg.body_length;
    assign tx.begin_mark  = data_reg.begin_mark;
    assign tx.end_mark    = data_reg.end_mark;

endmodule

/* sv/length_prefixed_frame_deframer.sv */
// length_prefixed_frame_deframer: top level, parser, queue and output stage
// depends on lpfd_pkg, lpfd_if, lpfd_front, lpfd_queue, lpfd_back
`timescale 1ns / 1ps

// Usage
//   rx carries the received byte stream, one byte per transaction (valid/ready).
//   tx carries one record per input byte: the field code, the byte itself,
//   the header values assembled so far, and frame_done with the end mark on
//   the last byte of each frame. Frames follow each other with no gap.
//   A byte accepted by the parser is written into the queue and then into
//   the output register, from which it is presented on tx.
//   Throughput: one byte per cycle while the queue has room; the parser does
//   at most one shift and one 33-bit count compare per byte.
//   Reset puts the parser at the begin mark with all header values zero and
//   empties the queue and the output register.
//   When tx stalls, the output register holds and the queue fills; rx.ready
//   drops only once the queue is full and rises as soon as an entry drains.

module length_prefixed_frame_deframer #(
    parameter int REQUEST_ID_BYTES = 68
) (
    input  logic       clk,
    input  logic       rst_n,
    lpfd_byte_if.sink  rx,
    lpfd_rec_if.source tx
);
    import lpfd_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    rec_t wr_data;
    rec_t rd_data;

    lpfd_front #(
        .REQUEST_ID_BYTES (REQUEST_ID_BYTES)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .full  (full),
        .push  (push),
        .rec   (wr_data)
    );

    lpfd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_data),
        .pop     (pop),
        .rd_data (rd_data),
        .full    (full),
        .empty   (empty)
    );

    lpfd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .empty   (empty),
        .rd_data (rd_data),
        .pop     (pop),
        .tx      (tx)
    );

endmodule

/* tb/tb_length_prefixed_frame_deframer.sv */
// tb_length_prefixed_frame_deframer: streams frames into the deframer and checks every
// output record against an in-bench frame parser; depends on lpfd_pkg, lpfd_if and the dut
`timescale 1ns / 1ps

module tb_length_prefixed_frame_deframer;
    import lpfd_pkg::*;

    localparam int REQID_BYTES = 68;
    localparam int ITEM_TARGET = 1150;
    localparam longint LIMIT_NS = 5_000_000;

    // one stream byte, optionally held back until the dut has drained
    typedef struct packed {
        logic       drain_first;
        logic [7:0] value;
    } stream_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lpfd_byte_if rx_if ();
    lpfd_rec_if  tx_if ();

    length_prefixed_frame_deframer #(
        .REQUEST_ID_BYTES(REQID_BYTES)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .rx   (rx_if),
        .tx   (tx_if)
    );

    always #5 clk = ~clk;

    stream_byte_t pending_bytes[$];
    rec_t         predicted_recs[$];
    int           total_items = 0;
    int           accepted_count = 0;
    int           mismatches = 0;
    bit           offer_pending = 1'b0;

    // frame parser state
    logic [3:0]  parse_phase = FC_BEGIN;
    logic [32:0] field_count = '0;
    logic [7:0]  type_q = '0;
    logic [63:0] ident_q = '0;
    logic [63:0] time_q = '0;
    logic [31:0] length_q = '0;
    logic [15:0] begin_q = '0;
    logic [15:0] end_q = '0;

    // parse one accepted byte and queue the record it produces
    function automatic void parse_byte(input logic [7:0] b);
        logic [3:0]  ph;
        logic [3:0]  nxt;
        logic [32:0] size;
        logic        done;
        rec_t        r;
        ph = (parse_phase > FC_END) ? FC_BEGIN : parse_phase;
        done = 1'b0;
        case (ph)
            FC_TYPE:
            begin
                type_q = b;
                size = 33'(TYPE_BYTES);
                nxt = FC_IDENT;
            end
            FC_IDENT:
            begin
                ident_q = {ident_q[55:0], b};
                size = 33'(IDENT_BYTES);
                nxt = FC_REQID;
            end
            FC_REQID:
            begin
                // request id bytes are tagged but not stored
                size = 33'(REQID_BYTES);
                nxt = FC_TIME;
            end
            FC_TIME:
            begin
                time_q = {time_q[55:0], b};
                size = 33'(TIME_BYTES);
                nxt = FC_LENGTH;
            end
            FC_LENGTH:
            begin
                length_q = {length_q[23:0], b};
                size = 33'(LENGTH_BYTES);
                nxt = FC_PREFIX;
            end
            FC_PREFIX:
            begin
                // empty body goes straight to the end mark
                size = 33'(PREFIX_BYTES);
                nxt = (length_q == 32'd0) ? FC_END : FC_BODY;
            end
            FC_BODY:
            begin
                size = {1'b0, length_q};
                nxt = FC_END;
            end
            FC_END:
            begin
                end_q = {end_q[7:0], b};
                size = 33'(END_BYTES);
                nxt = FC_BEGIN;
            end
            default:
            begin
                begin_q = {begin_q[7:0], b};
                size = 33'(BEGIN_BYTES);
                nxt = FC_TYPE;
            end
        endcase

        field_count = field_count + 33'd1;
        if (field_count >= size)
        begin
            field_count = '0;
            done = (ph == FC_END);
            parse_phase = nxt;
        end
        else
        begin
            parse_phase = ph;
        end

        r.field_code  = ph;
        r.byte_out    = b;
        r.frame_done  = done;
        r.frame_type  = type_q;
        r.frame_ident = ident_q;
        r.frame_time  = time_q;
        r.body_length = length_q;
        r.begin_mark  = begin_q;
        r.end_mark    = done ? end_q : 16'h0000;
        predicted_recs.push_back(r);

        // frame end clears the header values
        if (done)
        begin
            type_q   = '0;
            ident_q  = '0;
            time_q   = '0;
            length_q = '0;
            begin_q  = '0;
            end_q    = '0;
        end
    endfunction

    function automatic void add_byte(input logic [7:0] v, input bit drain);
        pending_bytes.push_back({drain, v});
    endfunction

    // constant fill, or random when fill is negative
    function automatic logic [7:0] fill_byte(input int fill);
        return (fill < 0) ? 8'($urandom_range(255)) : fill[7:0];
    endfunction

    // queue one frame; a frame with fewer body bytes than its length stays open
    task automatic push_frame(input logic [15:0] begin_m, input logic [7:0] typ,
                              input logic [63:0] ident, input logic [63:0] tstamp,
                              input logic [31:0] len, input int body_bytes,
                              input logic [15:0] end_m, input int fill, input bit drain);
        add_byte(begin_m[15:8], drain);
        add_byte(begin_m[7:0], 1'b0);
        add_byte(typ, 1'b0);
        for (int i = 7; i >= 0; i--)
            add_byte(ident[i*8 +: 8], 1'b0);
        for (int i = 0; i < REQID_BYTES; i++)
            add_byte(fill_byte(fill), 1'b0);
        for (int i = 7; i >= 0; i--)
            add_byte(tstamp[i*8 +: 8], 1'b0);
        for (int i = 3; i >= 0; i--)
            add_byte(len[i*8 +: 8], 1'b0);
        for (int i = 0; i < PREFIX_BYTES; i++)
            add_byte(fill_byte(fill), 1'b0);
        for (int i = 0; i < body_bytes; i++)
            add_byte(fill_byte(fill), 1'b0);
        if (longint'(body_bytes) == longint'(len))
        begin
            add_byte(end_m[15:8], 1'b0);
            add_byte(end_m[7:0], 1'b0);
        end
    endtask

    // idle percentage of one side for the current traffic phase
    function automatic int idle_pct(input bit sink_side);
        int mode;
        mode = (total_items == 0) ? 0 : accepted_count * 4 / total_items;
        case (mode)
            0:       return 0;
            1:       return sink_side ? 0 : 63;
            2:       return sink_side ? 63 : 0;
            default: return 10;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // byte driver
    always @(negedge clk)
    begin : drive_rx
        stream_byte_t nxt;
        if (rst_n && !offer_pending)
        begin
            if (pending_bytes.size() == 0)
                rx_if.valid <= 1'b0;
            else if (pending_bytes[0].drain_first && predicted_recs.size() != 0)
                rx_if.valid <= 1'b0;
            else if ($urandom_range(99) < idle_pct(1'b0))
                rx_if.valid <= 1'b0;
            else
            begin
                nxt = pending_bytes.pop_front();
                rx_if.valid   <= 1'b1;
                rx_if.byte_in <= nxt.value;
                offer_pending = 1'b1;
            end
        end
    end

    // record sink back-pressure
    always @(negedge clk)
    begin : drive_tx_ready
        if (rst_n)
            tx_if.ready <= ($urandom_range(99) >= idle_pct(1'b1));
    end

    // monitor: check output records, predict on accepted bytes
    always @(posedge clk)
    begin : watch
        rec_t want;
        if (rst_n)
        begin
            if (tx_if.valid && tx_if.ready)
            begin
                if (predicted_recs.size() == 0)
                begin
                    $display("%0t: unexpected record: expected none, got code %0d byte %02h",
                             $time, tx_if.field_code, tx_if.byte_out);
                    mismatches++;
                end
                else
                begin
                    want = predicted_recs.pop_front();
                    check_field("field_code", 64'(want.field_code), 64'(tx_if.field_code));
                    check_field("byte_out", 64'(want.byte_out), 64'(tx_if.byte_out));
                    check_field("frame_done", 64'(want.frame_done), 64'(tx_if.frame_done));
                    check_field("frame_type", 64'(want.frame_type), 64'(tx_if.frame_type));
                    check_field("frame_ident", want.frame_ident, tx_if.frame_ident);
                    check_field("frame_time", want.frame_time, tx_if.frame_time);
                    check_field("body_length", 64'(want.body_length), 64'(tx_if.body_length));
                    check_field("begin_mark", 64'(want.begin_mark), 64'(tx_if.begin_mark));
                    check_field("end_mark", 64'(want.end_mark), 64'(tx_if.end_mark));
                end
            end
            if (rx_if.valid && rx_if.ready)
            begin
                parse_byte(rx_if.byte_in);
                accepted_count++;
                offer_pending = 1'b0;
            end
        end
    end

    // stimulus and end of run
    initial
    begin : run
        int          frame_idx;
        int          pick;
        logic [31:0] len;
        bit          noisy;
        rx_if.valid   = 1'b0;
        rx_if.byte_in = 8'h00;
        tx_if.ready   = 1'b0;

        // directed: all-zero frame with empty body, all-ones frame, mixed pattern
        push_frame(16'h0000, 8'h00, 64'h0, 64'h0, 32'd0, 0, 16'h0000, 0, 1'b0);
        push_frame(16'hFFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                   32'd1, 1, 16'hFFFF, 255, 1'b0);
        push_frame(16'h8001, 8'h5A, 64'h0123_4567_89AB_CDEF, 64'h8000_0000_0000_0001,
                   32'd3, 3, 16'h7FFE, -1, 1'b0);

        // random frames, mostly short bodies, some fully random noise frames
        frame_idx = 0;
        while (pending_bytes.size() < ITEM_TARGET - 120)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                len = 32'd0;
            else if (pick < 75)
                len = 32'($urandom_range(1, 8));
            else
                len = 32'($urandom_range(9, 60));
            noisy = ($urandom_range(99) < 15);
            if (noisy)
                len = 32'($urandom_range(255));
            push_frame(noisy ? 16'($urandom) : 16'hA55A, 8'($urandom),
                       {$urandom, $urandom}, {$urandom, $urandom}, len, int'(len),
                       noisy ? 16'($urandom) : 16'h5AA5, -1,
                       (frame_idx == 2) || ($urandom_range(5) == 0));
            frame_idx++;
        end

        // last frame declares the largest body and is cut off
        push_frame(16'($urandom), 8'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                   32'hFFFF_FFFF, 6, 16'h0000, -1, 1'b0);
        total_items = pending_bytes.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || offer_pending)
            @(posedge clk);
        while (predicted_recs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
